/* rtl/nsc_pkg.sv */
// nested comment stripper: shared constants, codes and payload types
// no dependencies; used by the interfaces, the result queue and the top level
package nsc_pkg;

  localparam int MAX_DEPTH   = 255;
  localparam int MAX_RUN     = 4096;
  localparam int BYTE_W      = 8;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int RUN_W       = $clog2(MAX_RUN + 1);
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_SPACES = 2'd1,
    KIND_EOL    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_OPEN = 2'd1,
    HELD_STAR = 2'd2
  } held_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic [RUN_W-1:0]  space_count;
    logic              last;
  } result_t;

  // up to two results written into the queue for one input transfer
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [RUN_W-1:0] run_add(input logic [RUN_W-1:0] run,
                                               input logic [1:0] k);
    logic [RUN_W:0] s;
    s = {1'b0, run} + (RUN_W + 1)'(k);
    return (s >= (RUN_W + 1)'(MAX_RUN)) ? RUN_W'(MAX_RUN) : s[RUN_W-1:0];
  endfunction

endpackage

/* rtl/nsc_in_if.sv */
// input channel: one source byte or end-of-line marker per transfer
// depends on nsc_pkg
interface nsc_in_if;
  import nsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              line_end;
  logic              clear_depth;

  modport source (output valid, text_byte, line_end, clear_depth, input ready);
  modport sink (input valid, text_byte, line_end, clear_depth, output ready);
endinterface

/* rtl/nsc_out_if.sv */
// result channel: character, run of spaces or end of line per transfer
// depends on nsc_pkg
interface nsc_out_if;
  import nsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic [RUN_W-1:0]  space_count;
  logic              last;

  modport source (output valid, kind, out_byte, space_count, last, input ready);
  modport sink (input valid, kind, out_byte, space_count, last, output ready);
endinterface

/* rtl/nsc_res_queue.sv */
// result queue: takes up to two results a cycle, hands out one a cycle
// depends on nsc_pkg; head entry drives the result channel directly
module nsc_res_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_en,
  input  nsc_pkg::push_t            push,
  input  logic                      pop,
  output nsc_pkg::result_t          head,
  output logic                      head_valid,
  output logic [nsc_pkg::CNT_W-1:0] count
);
  import nsc_pkg::*;

  result_t            q_r   [QUEUE_DEPTH];
  result_t            q_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   base;
  logic [1:0]         num;

  assign head       = q_r[0];
  assign head_valid = (cnt_r != '0);
  assign count      = cnt_r;

  always_comb begin
    num  = push_en ? push.num : 2'd0;
    base = cnt_r - CNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    q_nxt[QUEUE_DEPTH-1] = q_r[QUEUE_DEPTH-1];
    if (num != 2'd0) begin
      q_nxt[base[IDX_W-1:0]] = push.first;
    end
    if (num == 2'd2) begin
      q_nxt[base[IDX_W-1:0] + IDX_W'(1)] = push.second;
    end
    cnt_nxt = base + CNT_W'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

/* rtl/nested_comment_stripper.sv */
// nested comment stripper, top level: removes nested (* ... *) comments
// results are registered in the result queue on their input transfer and offered from its head
// throughput: one input item per cycle while ready is high; an item with two results needs two
//   output transfers, absorbed by the four-entry result queue (ready drops at three held)
// reset (rst_n low, synchronous): depth, held byte, comment run and queue cleared
// depends on nsc_pkg, nsc_in_if, nsc_out_if, nsc_res_queue
module nested_comment_stripper (
  input logic      clk,
  input logic      rst_n,
  nsc_in_if.sink   in_ch,
  nsc_out_if.source out_ch
);
  import nsc_pkg::*;

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  held_t              held_r, held_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;

  logic               in_fire;
  logic [CNT_W-1:0]   q_count;
  result_t            head;
  logic               head_valid;
  push_t              push;
  result_t            res [2];

  logic [DEPTH_W-1:0] d;
  logic [RUN_W-1:0]   run;
  logic [RUN_W-1:0]   run_base;
  held_t              h;
  logic [BYTE_W-1:0]  c;
  logic [1:0]         k;
  logic [1:0]         n;
  logic               do_take;
  logic               run_zero;

  assign in_ch.ready = (q_count <= CNT_W'(QUEUE_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    d         = in_ch.clear_depth ? '0 : depth_r;
    run       = in_ch.clear_depth ? '0 : run_r;
    h         = in_ch.clear_depth ? HELD_NONE : held_r;
    c         = in_ch.text_byte;
    k         = 2'd0;
    n         = 2'd0;
    do_take   = 1'b0;
    run_zero  = 1'b0;
    run_base  = run;
    depth_nxt = d;
    held_nxt  = HELD_NONE;
    res[0]    = '{kind: KIND_CHAR, out_byte: '0, space_count: '0, last: 1'b0};
    res[1]    = res[0];

    if (in_ch.line_end) begin
      if (d == '0 && h == HELD_OPEN) begin
        res[n[0]].out_byte = CH_OPEN;
        n = n + 2'd1;
      end else if (d == '0 && h == HELD_STAR) begin
        res[n[0]].out_byte = CH_STAR;
        n = n + 2'd1;
      end
      run_zero = 1'b1;
      res[n[0]].kind = KIND_EOL;
      n = n + 2'd1;
    end else begin
      case (h)
        HELD_OPEN: begin
          if (c == CH_STAR) begin
            if (d == '0) run_base = '0;
            k = 2'd2;
            if (d < DEPTH_W'(MAX_DEPTH)) depth_nxt = d + DEPTH_W'(1);
          end else begin
            if (d == '0) begin
              res[n[0]].out_byte = CH_OPEN;
              n = n + 2'd1;
            end else begin
              k = 2'd1;
            end
            do_take = 1'b1;
          end
        end
        HELD_STAR: begin
          if (d == '0) begin
            res[n[0]].out_byte = CH_STAR;
            n = n + 2'd1;
            do_take = 1'b1;
          end else if (c == CH_CLOSE) begin
            k = 2'd2;
            depth_nxt = d - DEPTH_W'(1);
            if (d == DEPTH_W'(1)) begin
              res[n[0]].kind        = KIND_SPACES;
              res[n[0]].space_count = run_add(run, 2'd2);
              n = n + 2'd1;
              run_zero = 1'b1;
            end
          end else begin
            k = 2'd1;
            do_take = 1'b1;
          end
        end
        default: begin
          do_take = 1'b1;
        end
      endcase

      if (do_take) begin
        if (c == CH_OPEN) begin
          held_nxt = HELD_OPEN;
        end else if (d == '0) begin
          res[n[0]].out_byte = c;
          n = n + 2'd1;
        end else if (c == CH_STAR) begin
          held_nxt = HELD_STAR;
        end else begin
          k = k + 2'd1;
        end
      end
    end

    run_nxt = run_zero ? '0 : run_add(run_base, k);

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;

    push.num    = n;
    push.first  = res[0];
    push.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      held_r  <= HELD_NONE;
      run_r   <= '0;
    end else if (in_fire) begin
      depth_r <= depth_nxt;
      held_r  <= held_nxt;
      run_r   <= run_nxt;
    end
  end

  nsc_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_fire),
    .push       (push),
    .pop        (out_ch.valid && out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  assign out_ch.valid       = head_valid;
  assign out_ch.kind        = head.kind;
  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.space_count = head.space_count;
  assign out_ch.last        = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue over capacity");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond limit");

  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.line_end && !(out_ch.valid && out_ch.ready) |=> q_count > $past(q_count))
    else $error("end of line transfer left no result");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_SPACES |-> out_ch.space_count >= RUN_W'(2))
    else $error("space run shorter than a closing bracket pair");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.line_end |=> run_r == '0 && held_r == HELD_NONE)
    else $error("line end did not clear run or held byte");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for nested_comment_stripper, directed table, random text, then a deep nesting line
// depends on nsc_pkg, nsc_in_if, nsc_out_if and the rtl top level

module tb_top;
  import nsc_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 80;
  localparam int N_ROWS      = 24;
  localparam int MAX_SHOWN   = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              e;
    logic              c;
    logic              chk;
    kind_t             k;
    logic [BYTE_W-1:0] ob;
    logic [RUN_W-1:0]  n;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  nsc_in_if  in_ch();
  nsc_out_if out_ch();

  nested_comment_stripper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  result_t            expected_tokens[$];
  row_t               dir_rows[N_ROWS];
  logic [DEPTH_W-1:0] nest_depth;
  held_t              held_ch;
  logic [RUN_W-1:0]   line_run;
  int                 snd_idle, rcv_idle;
  int                 err_cnt, cycles, in_xfers, out_xfers;
  int                 hold_cnt, deepest, longest_run;
  bit                 hold_req;

  function automatic logic [RUN_W-1:0] bump_run(input logic [RUN_W-1:0] r, input int k);
    int s;
    s = int'(r) + k;
    return (s >= MAX_RUN) ? RUN_W'(MAX_RUN) : RUN_W'(s);
  endfunction

  function automatic result_t token(input kind_t k, input logic [BYTE_W-1:0] b,
                                    input logic [RUN_W-1:0] n);
    result_t t;
    t.kind        = k;
    t.out_byte    = b;
    t.space_count = n;
    t.last        = 1'b0;
    return t;
  endfunction

  function automatic void absorb_char(input logic [BYTE_W-1:0] c);
    if (nest_depth == 0) begin
      if (c == CH_OPEN) held_ch = HELD_OPEN;
      else expected_tokens.push_back(token(KIND_CHAR, c, '0));
    end else if (c == CH_OPEN) begin
      held_ch = HELD_OPEN;
    end else if (c == CH_STAR) begin
      held_ch = HELD_STAR;
    end else begin
      line_run = bump_run(line_run, 1);
    end
  endfunction

  // returns the number of results this transfer causes
  function automatic int predict_strip(input logic [BYTE_W-1:0] c, input logic eol,
                                       input logic clr);
    held_t   h;
    int      n0;
    result_t t;
    n0 = expected_tokens.size();
    if (clr) begin
      nest_depth = '0;
      line_run   = '0;
      held_ch    = HELD_NONE;
    end
    h       = held_ch;
    held_ch = HELD_NONE;
    if (eol) begin
      if (nest_depth == 0) begin
        if (h == HELD_OPEN) expected_tokens.push_back(token(KIND_CHAR, CH_OPEN, '0));
        else if (h == HELD_STAR) expected_tokens.push_back(token(KIND_CHAR, CH_STAR, '0));
      end
      line_run = '0;
      expected_tokens.push_back(token(KIND_EOL, '0, '0));
    end else if (h == HELD_OPEN) begin
      if (c == CH_STAR) begin
        if (nest_depth == 0) line_run = '0;
        line_run = bump_run(line_run, 2);
        if (nest_depth < MAX_DEPTH) nest_depth = nest_depth + 1'b1;
      end else begin
        if (nest_depth == 0) expected_tokens.push_back(token(KIND_CHAR, CH_OPEN, '0));
        else line_run = bump_run(line_run, 1);
        absorb_char(c);
      end
    end else if (h == HELD_STAR) begin
      if (nest_depth == 0) begin
        expected_tokens.push_back(token(KIND_CHAR, CH_STAR, '0));
        absorb_char(c);
      end else if (c == CH_CLOSE) begin
        line_run   = bump_run(line_run, 2);
        nest_depth = nest_depth - 1'b1;
        if (nest_depth == 0) begin
          expected_tokens.push_back(token(KIND_SPACES, '0, line_run));
          if (int'(line_run) > longest_run) longest_run = line_run;
          line_run = '0;
        end
      end else begin
        line_run = bump_run(line_run, 1);
        absorb_char(c);
      end
    end else begin
      absorb_char(c);
    end
    if (int'(nest_depth) > deepest) deepest = nest_depth;
    if (expected_tokens.size() > n0) begin
      t      = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
    return expected_tokens.size() - n0;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (err_cnt < MAX_SHOWN)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    err_cnt++;
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic e, input logic c,
                           output int n_res);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.line_end    <= e;
    in_ch.clear_depth <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_res = predict_strip(b, e, c);
    in_xfers++;
    @(negedge clk);
  endtask

  task automatic send_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    int n_res;
    send_item(a, 1'b0, 1'b0, n_res);
    send_item(b, 1'b0, 1'b0, n_res);
  endtask

  // random text of bracket pairs, single brackets, plain bytes, line ends and depth clears; closes favoured once deep
  task automatic send_text(input int n_items);
    int sent, r, n_res;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, n_res);
        sent++;
      end else if (r < 8) begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, n_res);
        sent++;
      end else if (r < 22 && (nest_depth < 6 || r < 12)) begin
        send_pair(CH_OPEN, CH_STAR);
        sent += 2;
      end else if (r < 36) begin
        send_pair(CH_STAR, CH_CLOSE);
        sent += 2;
      end else if (r < 42) begin
        send_item(CH_OPEN, 1'b0, 1'b0, n_res);
        sent++;
      end else if (r < 48) begin
        send_item(CH_STAR, 1'b0, 1'b0, n_res);
        sent++;
      end else if (r < 52) begin
        send_item(CH_CLOSE, 1'b0, 1'b0, n_res);
        sent++;
      end else begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0, n_res);
        sent++;
      end
    end
  endtask

  // one line that drives the nesting depth into saturation and back out
  task automatic send_deep_line();
    int n_res;
    repeat (MAX_DEPTH + 2) send_pair(CH_OPEN, CH_STAR);
    repeat (16) send_item(8'($urandom_range(255)), 1'b0, 1'b0, n_res);
    repeat (MAX_DEPTH + 2) send_pair(CH_STAR, CH_CLOSE);
    send_item(8'($urandom_range(255)), 1'b1, 1'b0, n_res);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    result_t w;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_tokens.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      out_xfers++;
      if (expected_tokens.size() == 0) begin
        report("result transfer with none pending, kind", int'(out_ch.kind), -1);
      end else begin
        w = expected_tokens.pop_front();
        if (out_ch.kind !== w.kind) report("kind", int'(out_ch.kind), int'(w.kind));
        if (out_ch.out_byte !== w.out_byte)
          report("out_byte", int'(out_ch.out_byte), int'(w.out_byte));
        if (out_ch.space_count !== w.space_count)
          report("space_count", int'(out_ch.space_count), int'(w.space_count));
        if (out_ch.last !== w.last) report("last", int'(out_ch.last), int'(w.last));
      end
    end
  end

  initial begin
    int n_res;
    result_t t;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.line_end    = 1'b0;
    in_ch.clear_depth = 1'b0;
    out_ch.ready      = 1'b0;
    nest_depth        = '0;
    held_ch           = HELD_NONE;
    line_run          = '0;
    snd_idle          = 35;
    rcv_idle          = 77;

    dir_rows[0]  = '{8'h41, 1'b0, 1'b0, 1'b1, KIND_CHAR, 8'h41, '0};
    dir_rows[1]  = '{8'h00, 1'b0, 1'b0, 1'b1, KIND_CHAR, 8'h00, '0};
    dir_rows[2]  = '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_CHAR, 8'hFF, '0};
    dir_rows[3]  = '{8'h5A, 1'b1, 1'b0, 1'b1, KIND_EOL, 8'h00, '0};
    dir_rows[4]  = '{CH_OPEN, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[5]  = '{CH_STAR, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[6]  = '{CH_OPEN, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[7]  = '{CH_STAR, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[8]  = '{8'h78, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    // comment still open: its bytes are dropped
    dir_rows[9]  = '{8'hA5, 1'b1, 1'b0, 1'b1, KIND_EOL, 8'h00, '0};
    dir_rows[10] = '{CH_STAR, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[11] = '{CH_CLOSE, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[12] = '{CH_STAR, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    // run counted from the line start
    dir_rows[13] = '{CH_CLOSE, 1'b0, 1'b0, 1'b1, KIND_SPACES, 8'h00, RUN_W'(4)};
    // stray close is plain text
    dir_rows[14] = '{CH_STAR, 1'b0, 1'b0, 1'b1, KIND_CHAR, CH_STAR, '0};
    dir_rows[15] = '{CH_CLOSE, 1'b0, 1'b0, 1'b1, KIND_CHAR, CH_CLOSE, '0};
    dir_rows[16] = '{CH_OPEN, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[17] = '{8'h00, 1'b1, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[18] = '{CH_OPEN, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[19] = '{CH_STAR, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    // new file drops the open comment
    dir_rows[20] = '{8'h71, 1'b0, 1'b1, 1'b1, KIND_CHAR, 8'h71, '0};
    dir_rows[21] = '{CH_OPEN, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[22] = '{8'h7A, 1'b0, 1'b0, 1'b0, KIND_CHAR, 8'h00, '0};
    dir_rows[23] = '{8'h80, 1'b1, 1'b1, 1'b1, KIND_EOL, 8'h00, '0};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].e, dir_rows[i].c, n_res);
      if (dir_rows[i].chk) begin
        repeat (n_res) void'(expected_tokens.pop_back());
        t      = token(dir_rows[i].k, dir_rows[i].ob, dir_rows[i].n);
        t.last = 1'b1;
        expected_tokens.push_back(t);
      end
    end
    send_text(120);

    snd_idle = 77;
    rcv_idle = 35;
    hold_req = 1'b1;
    send_text(120);

    // drain before the back-to-back phase
    snd_idle    = 0;
    rcv_idle    = 0;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_tokens.size() != 0) @(negedge clk);
    send_text(120);
    send_deep_line();

    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d input transfers, %0d result transfers, %0d mismatches", in_xfers,
             out_xfers, err_cnt);
    $display("deepest nesting %0d, longest space run %0d", deepest, longest_run);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
